@@ hdl/b2s7_pkg.sv @@
`default_nettype none

package b2s7_pkg;

    localparam int unsigned C_VALUE_W = 16;
    localparam int unsigned C_SEG_W   = 8;
    localparam int unsigned C_DIGIT_W = 4;
    localparam int unsigned C_STAGES  = 5;

    localparam logic [C_SEG_W-1:0] C_SEG_BLANK = 8'hFF;

    // Reciprocal of ten, exact for every 16-bit dividend.
    localparam logic [15:0] C_RECIP10       = 16'hCCCD;
    localparam int unsigned C_RECIP10_SHIFT = 19;

    // Reciprocal of ten for dividends below one hundred.
    localparam logic [7:0]  C_RECIP10_SMALL       = 8'd205;
    localparam int unsigned C_RECIP10_SMALL_SHIFT = 11;

    typedef logic [C_DIGIT_W-1:0] t_digit;
    typedef logic [C_SEG_W-1:0]   t_seg;

    function automatic logic [12:0] f_div10(input logic [C_VALUE_W-1:0] x);
        logic [31:0] prod;
        prod = {16'd0, x} * {16'd0, C_RECIP10};
        return prod[31:C_RECIP10_SHIFT];
    endfunction

    function automatic t_seg f_seg(input t_digit d);
        t_seg s;
        unique case (d)
            4'd0:    s = 8'b1100_0000;
            4'd1:    s = 8'b1111_1001;
            4'd2:    s = 8'b1010_0100;
            4'd3:    s = 8'b1011_0000;
            4'd4:    s = 8'b1001_1001;
            4'd5:    s = 8'b1001_0010;
            4'd6:    s = 8'b1000_0010;
            4'd7:    s = 8'b1111_1000;
            4'd8:    s = 8'b1000_0000;
            4'd9:    s = 8'b1001_0000;
            default: s = C_SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hdl/binary_to_blanked_seven_segment.sv @@
// Binary to blanked seven-segment encoder for a four-digit common-anode display.
// Input channel: i_valid, i_value and o_stall; a request is taken at a rising
// edge where i_valid is high and o_stall is low.
// Output channel: o_valid, the five segment bytes and i_stall; a result is taken
// at a rising edge where o_valid is high and i_stall is low.
// Only the value modulo 10000 is shown, leading zeros are blanked and the colon
// position is always blank.
// The pipeline has five register stages, four of them a divide-by-ten through
// a reciprocal multiplier, so one request is taken every cycle while the
// receiver does not stall.
// Each stage moves forward when its successor is empty or moving, so bubbles
// are squeezed out while the receiver stalls; o_stall rises only once all
// five stages are full and the output stage is held.
// Reset empties every stage and drops any request in flight.
`default_nettype none

module binary_to_blanked_seven_segment
    import b2s7_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [C_VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [C_SEG_W-1:0]        o_units_segments,
    output logic [C_SEG_W-1:0]        o_tens_segments,
    output logic [C_SEG_W-1:0]        o_colon_segments,
    output logic [C_SEG_W-1:0]        o_hundreds_segments,
    output logic [C_SEG_W-1:0]        o_thousands_segments
);

    logic [C_STAGES-1:0] r_vld;
    logic [C_STAGES-1:0] ready;

    logic [C_VALUE_W-1:0] r1_v;
    logic [12:0]          r1_q1;

    t_digit r2_d0;
    logic [12:0] r2_q1;
    logic [9:0]  r2_q2;

    t_digit r3_d0, r3_d1;
    logic [9:0] r3_q2;
    logic [6:0] r3_q3;

    t_digit r4_d0, r4_d1, r4_d2, r4_d3;

    t_seg r5_units, r5_tens, r5_hundreds, r5_thousands;

    logic [15:0] n2_q1x10;
    t_digit      n2_d0;
    logic [12:0] n2_q2;
    logic [12:0] n3_q2x10;
    t_digit      n3_d1;
    logic [12:0] n3_q3;
    logic [9:0]  n4_q3x10;
    t_digit      n4_d2;
    logic [13:0] n4_prod;
    logic [2:0]  n4_q4;
    logic [6:0]  n4_q4x10;
    t_digit      n4_d3;
    logic        lead3, lead2, lead1;

    always_comb begin
        ready[C_STAGES-1] = !r_vld[C_STAGES-1] || !i_stall;
        for (int k = C_STAGES - 2; k >= 0; k--) begin
            ready[k] = !r_vld[k] || ready[k+1];
        end
    end

    assign o_stall = !ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ready[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < C_STAGES; k++) begin
                if (ready[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        n2_q1x10 = {r1_q1, 3'd0} + {2'd0, r1_q1, 1'd0};
        n2_d0    = 4'(r1_v - n2_q1x10);
        n2_q2    = f_div10({3'd0, r1_q1});

        n3_q2x10 = {r2_q2, 3'd0} + {2'd0, r2_q2, 1'd0};
        n3_d1    = 4'(r2_q1 - n3_q2x10);
        n3_q3    = f_div10({6'd0, r2_q2});

        n4_q3x10 = {r3_q3, 3'd0} + {2'd0, r3_q3, 1'd0};
        n4_d2    = 4'(r3_q2 - n4_q3x10);
        n4_prod  = {7'd0, r3_q3} * {6'd0, C_RECIP10_SMALL};
        n4_q4    = n4_prod[13:C_RECIP10_SMALL_SHIFT];
        n4_q4x10 = {1'd0, n4_q4, 3'd0} + {3'd0, n4_q4, 1'd0};
        n4_d3    = 4'(r3_q3 - n4_q4x10);

        lead3 = (r4_d3 == '0);
        lead2 = lead3 && (r4_d2 == '0);
        lead1 = lead2 && (r4_d1 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (ready[0]) begin
            r1_v  <= i_value;
            r1_q1 <= f_div10(i_value);
        end
        if (ready[1]) begin
            r2_d0 <= n2_d0;
            r2_q1 <= r1_q1;
            r2_q2 <= n2_q2[9:0];
        end
        if (ready[2]) begin
            r3_d0 <= r2_d0;
            r3_d1 <= n3_d1;
            r3_q2 <= r2_q2;
            r3_q3 <= n3_q3[6:0];
        end
        if (ready[3]) begin
            r4_d0 <= r3_d0;
            r4_d1 <= r3_d1;
            r4_d2 <= n4_d2;
            r4_d3 <= n4_d3;
        end
        if (ready[4]) begin
            r5_units     <= f_seg(r4_d0);
            r5_tens      <= lead1 ? C_SEG_BLANK : f_seg(r4_d1);
            r5_hundreds  <= lead2 ? C_SEG_BLANK : f_seg(r4_d2);
            r5_thousands <= lead3 ? C_SEG_BLANK : f_seg(r4_d3);
        end
    end

    assign o_valid              = r_vld[C_STAGES-1];
    assign o_units_segments     = r5_units;
    assign o_tens_segments      = r5_tens;
    assign o_colon_segments     = C_SEG_BLANK;
    assign o_hundreds_segments  = r5_hundreds;
    assign o_thousands_segments = r5_thousands;

    a_units_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_units_segments != C_SEG_BLANK)
        else $error("units digit blanked");

    a_blank_run_hundreds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hundreds_segments == C_SEG_BLANK |->
        o_thousands_segments == C_SEG_BLANK)
        else $error("hundreds blanked below a shown thousands digit");

    a_blank_run_tens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tens_segments == C_SEG_BLANK |->
        o_hundreds_segments == C_SEG_BLANK)
        else $error("tens blanked below a shown hundreds digit");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld) && i_stall)
        else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire
